### hw/rtl/q5k_pkg.sv
// Shared types, constants and the fp32 to fp16 narrowing function
// for the Q5_K super-block dequantizer. No dependencies.
package q5k_pkg;

  localparam logic [4:0] PosHdr0    = 5'd0;
  localparam logic [4:0] PosHdr1    = 5'd1;
  localparam logic [4:0] NibbleBase = 5'd6;
  localparam logic [4:0] PosLast    = 5'd21;

  localparam logic [31:0] QNan32 = 32'h7FC0_0000;
  localparam logic [15:0] QNan16 = 16'h7E00;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } ctrl_state_e;

  typedef struct packed {
    logic       load;
    logic [4:0] pos;
    logic       issue;
    logic [1:0] run;
    logic [5:0] k;
  } ctrl_cmd_t;

  typedef struct packed {
    logic busy;
    logic advance;
  } dp_status_t;

  function automatic logic [15:0] f32_to_f16(input logic [31:0] u);
    logic              s;
    logic [7:0]        ef;
    logic [23:0]       m;
    logic signed [9:0] e;
    logic [4:0]        sh;
    logic [23:0]       mm;
    logic [23:0]       r;
    logic [23:0]       half;
    logic [10:0]       mr;
    logic [12:0]       r13;
    logic signed [9:0] ee;
    logic [15:0]       res;
    s   = u[31];
    ef  = u[30:23];
    m   = {1'b0, u[22:0]};
    e   = $signed({2'b00, ef}) - 10'sd112;
    sh  = '0;
    mm  = '0;
    r   = '0;
    half = '0;
    mr  = '0;
    r13 = '0;
    ee  = e;
    if (ef == 8'hFF) begin
      res = (m != '0) ? QNan16 : {s, 15'h7C00};
    end else if (e <= 10'sd0) begin
      if (e < -10'sd10) begin
        res = {s, 15'h0000};
      end else begin
        m[23] = 1'b1;
        sh    = 5'(10'sd14 - e);
        mm    = m >> sh;
        r     = m & ((24'd1 << sh) - 24'd1);
        half  = 24'd1 << (sh - 5'd1);
        if (r > half || (r == half && mm[0])) begin
          mm = mm + 24'd1;
        end
        res = {s, mm[14:0]};
      end
    end else if (e >= 10'sd31) begin
      res = {s, 15'h7C00};
    end else begin
      r13 = m[12:0];
      mr  = {1'b0, m[22:13]};
      if (r13 > 13'h1000 || (r13 == 13'h1000 && mr[0])) begin
        mr = mr + 11'd1;
        if (mr[10]) begin
          mr = '0;
          ee = ee + 10'sd1;
        end
      end
      if (ee >= 10'sd31) begin
        res = {s, 15'h7C00};
      end else begin
        res = {s, ee[4:0], mr[9:0]};
      end
    end
    return res;
  endfunction

endpackage

### hw/rtl/q5k_ctrl.sv
// Sequencer: tracks the word position in the super-block and issues the
// 64 elements of a run to the datapath. Uses q5k_pkg.
module q5k_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  q5k_pkg::dp_status_t   status_i,
  output q5k_pkg::ctrl_cmd_t    cmd_o
);
  import q5k_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [4:0]  pos_q, pos_d;
  logic [1:0]  run_q, run_d;
  logic [5:0]  k_q, k_d;
  logic        accept;
  logic        fire;
  logic [4:0]  rel;

  assign in_ready_o = (state_q == ST_IDLE) && !status_i.busy;
  assign accept     = in_valid_i && in_ready_o;
  assign rel        = pos_q - NibbleBase;

  assign cmd_o.load  = accept;
  assign cmd_o.pos   = pos_q;
  assign cmd_o.issue = (state_q == ST_EMIT);
  assign cmd_o.run   = run_q;
  assign cmd_o.k     = k_q;
  assign fire        = cmd_o.issue && status_i.advance;

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    run_d   = run_q;
    k_d     = k_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pos_d = (pos_q == PosLast) ? 5'd0 : pos_q + 5'd1;
          // fourth word of a nibble chunk starts a run
          if (pos_q >= NibbleBase && rel[1:0] == 2'd3) begin
            state_d = ST_EMIT;
            run_d   = rel[3:2];
            k_d     = '0;
          end
        end
      end
      ST_EMIT: begin
        if (fire) begin
          k_d = k_q + 6'd1;
          if (k_q == 6'd63) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      run_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      run_q   <= run_d;
      k_q     <= k_d;
    end
  end

endmodule

### hw/rtl/q5k_dp.sv
// Datapath: block storage and the element pipeline (multiply, align,
// add, normalise, round, narrow). Uses q5k_pkg; driven by q5k_ctrl.
module q5k_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  q5k_pkg::ctrl_cmd_t  cmd_i,
  output q5k_pkg::dp_status_t status_o,
  input  logic [63:0]         data_word_i,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         value_o,
  output logic [7:0]          element_index_o,
  output logic                last_in_run_o,
  output logic                last_in_block_o
);
  import q5k_pkg::*;

  typedef struct packed {
    logic [7:0] idx;
    logic       lrun;
    logic       lblk;
    logic       nan;
    logic       inf;
    logic       isg;
  } meta_t;

  localparam int unsigned NStage = 10;

  // block storage
  logic [15:0] d_half_q, m_half_q;
  logic [7:0]  sc_bytes_q [12];
  logic [7:0]  qh_q [32];
  logic [7:0]  nib_q [32];
  logic        fmt_q;
  logic [4:0]  rel;

  assign rel = cmd_i.pos - NibbleBase;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (cmd_i.pos == PosHdr0) begin
        d_half_q <= data_word_i[15:0];
        m_half_q <= data_word_i[31:16];
        for (int i = 0; i < 4; i++) begin
          sc_bytes_q[i] <= data_word_i[32 + 8 * i +: 8];
        end
      end else if (cmd_i.pos == PosHdr1) begin
        for (int i = 0; i < 8; i++) begin
          sc_bytes_q[4 + i] <= data_word_i[8 * i +: 8];
        end
      end else if (cmd_i.pos < NibbleBase) begin
        for (int i = 0; i < 8; i++) begin
          qh_q[{cmd_i.pos[1:0] - 2'd2, 3'(i)}] <= data_word_i[8 * i +: 8];
        end
      end else begin
        for (int i = 0; i < 8; i++) begin
          nib_q[{rel[1:0], 3'(i)}] <= data_word_i[8 * i +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= 1'b0;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  // header decode, stable for the whole run
  logic [4:0]  d_exp, m_exp, d_eff, m_eff, emin;
  logic [10:0] d_man, m_man;
  logic        d_spec, m_spec, d_nan, m_nan, sd, sm, same;

  assign d_exp  = d_half_q[14:10];
  assign m_exp  = m_half_q[14:10];
  assign d_man  = {d_exp != 5'd0, d_half_q[9:0]};
  assign m_man  = {m_exp != 5'd0, m_half_q[9:0]};
  assign d_eff  = (d_exp == 5'd0) ? 5'd1 : d_exp;
  assign m_eff  = (m_exp == 5'd0) ? 5'd1 : m_exp;
  assign emin   = (d_eff < m_eff) ? d_eff : m_eff;
  assign d_spec = (d_exp == 5'h1F);
  assign m_spec = (m_exp == 5'h1F);
  assign d_nan  = d_spec && (d_half_q[9:0] != 10'd0);
  assign m_nan  = m_spec && (m_half_q[9:0] != 10'd0);
  assign sd     = d_half_q[15];
  assign sm     = m_half_q[15];
  assign same   = (sd == sm);

  // pipeline control: stall everything while the result waits
  logic en;
  logic [NStage-1:0] vld_q;
  meta_t meta_q [NStage];

  assign en = !out_valid_o || out_ready_i;
  assign status_o.advance = en;
  assign status_o.busy    = (|vld_q) || out_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStage-2:0], cmd_i.issue};
    end
  end

  // stage 1: fetch q, sc and mn
  logic [4:0] l;
  logic       hf;
  logic [2:0] sb;
  logic [7:0] nbyte, hi_byte;
  logic [4:0] q_d;
  logic [5:0] sc_d, mn_d;
  logic [4:0] q1_q;
  logic [5:0] sc1_q, mn1_q;
  meta_t      meta1_d;

  assign l       = cmd_i.k[4:0];
  assign hf      = cmd_i.k[5];
  assign sb      = {cmd_i.run, hf};
  assign nbyte   = nib_q[l];
  assign q_d     = {qh_q[l][sb], hf ? nbyte[7:4] : nbyte[3:0]};
  assign hi_byte = sc_bytes_q[{2'b10, sb[1:0]}];

  always_comb begin
    if (!sb[2]) begin
      sc_d = sc_bytes_q[{2'b00, sb[1:0]}][5:0];
      mn_d = sc_bytes_q[{2'b01, sb[1:0]}][5:0];
    end else begin
      sc_d = {sc_bytes_q[{2'b00, sb[1:0]}][7:6], hi_byte[3:0]};
      mn_d = {sc_bytes_q[{2'b01, sb[1:0]}][7:6], hi_byte[7:4]};
    end
    meta1_d      = '0;
    meta1_d.idx  = {cmd_i.run, cmd_i.k};
    meta1_d.lrun = (cmd_i.k == 6'd63);
    meta1_d.lblk = (cmd_i.k == 6'd63) && (cmd_i.run == 2'd3);
  end

  // stage 2: d*sc, dmin*mn, special classes
  logic [16:0] a1_q, b2_q, b3_q;
  logic [4:0]  q2_q;
  meta_t       meta2_d;
  logic        zsq, zm, a_nan, a_inf, b_nan, b_inf;

  always_comb begin
    zsq   = (sc1_q == 6'd0) || (q1_q == 5'd0);
    zm    = (mn1_q == 6'd0);
    a_nan = d_nan || (d_spec && zsq);
    a_inf = d_spec && !zsq && !d_nan;
    b_nan = m_nan || (m_spec && zm);
    b_inf = m_spec && !zm && !m_nan;
    meta2_d     = meta_q[0];
    meta2_d.nan = a_nan || b_nan || (a_inf && b_inf && same);
    meta2_d.inf = !meta2_d.nan && (a_inf || b_inf);
    meta2_d.isg = a_inf ? sd : !sm;
  end

  // stages 3..10 payload
  logic [21:0] a3_q;
  logic [52:0] ash_q, bsh_q, r5_q, mag6_q;
  logic        sign6_q, sign7_q, sign8_q, sign9_q;
  logic [55:0] magx, mag7_q, mag8_q, norm9_q;
  logic [13:0] nz_d, nz_q;
  logic [1:0]  gp_d [14];
  logic [1:0]  gp_q [14];
  logic [5:0]  p_d, p8_q, p9_q;
  logic        zero8_q, zero9_q;
  logic [31:0] f32_d, f32_q;

  assign magx = {3'b000, mag6_q};

  always_comb begin
    for (int g = 0; g < 14; g++) begin
      nz_d[g] = |magx[4 * g +: 4];
      gp_d[g] = magx[4 * g + 3] ? 2'd3 :
                magx[4 * g + 2] ? 2'd2 :
                magx[4 * g + 1] ? 2'd1 : 2'd0;
    end
    p_d = '0;
    for (int g = 0; g < 14; g++) begin
      if (nz_q[g]) begin
        p_d = {4'(g), gp_q[g]};
      end
    end
  end

  // stage 10: round to nearest even and pack fp32
  logic [23:0] m24;
  logic        guard, sticky, up;
  logic [24:0] m25;
  logic [8:0]  e9;

  always_comb begin
    m24    = norm9_q[55:32];
    guard  = norm9_q[31];
    sticky = |norm9_q[30:0];
    up     = guard && (sticky || m24[0]);
    m25    = {1'b0, m24} + {24'd0, up};
    e9     = {3'b000, p9_q} + {4'b0000, emin} + 9'd102 + {8'd0, m25[24]};
    if (meta_q[8].nan) begin
      f32_d = QNan32;
    end else if (meta_q[8].inf) begin
      f32_d = {meta_q[8].isg, 8'hFF, 23'd0};
    end else if (zero9_q) begin
      f32_d = {sign9_q, 31'd0};
    end else begin
      f32_d = {sign9_q, e9[7:0], m25[22:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q1_q      <= q_d;
      sc1_q     <= sc_d;
      mn1_q     <= mn_d;
      meta_q[0] <= meta1_d;

      a1_q      <= 17'(d_man) * 17'(sc1_q);
      b2_q      <= 17'(m_man) * 17'(mn1_q);
      q2_q      <= q1_q;
      meta_q[1] <= meta2_d;

      a3_q      <= 22'(a1_q) * 22'(q2_q);
      b3_q      <= b2_q;

      ash_q     <= 53'(a3_q) << (d_eff - emin);
      bsh_q     <= 53'(b3_q) << (m_eff - emin);

      r5_q      <= same ? ash_q - bsh_q : ash_q + bsh_q;

      // take the magnitude; an exact zero follows the signed-zero rule
      mag6_q    <= (same && r5_q[52]) ? -r5_q : r5_q;
      sign6_q   <= (r5_q == '0) ? (sd && !same) : (sd ^ (same && r5_q[52]));

      mag7_q    <= magx;
      nz_q      <= nz_d;
      gp_q      <= gp_d;
      sign7_q   <= sign6_q;

      p8_q      <= p_d;
      zero8_q   <= (nz_q == '0);
      mag8_q    <= mag7_q;
      sign8_q   <= sign7_q;

      norm9_q   <= mag8_q << (6'd55 - p8_q);
      p9_q      <= p8_q;
      zero9_q   <= zero8_q;
      sign9_q   <= sign8_q;

      f32_q     <= f32_d;

      for (int s = 2; s < NStage; s++) begin
        meta_q[s] <= meta_q[s-1];
      end
    end
  end

  // output register
  logic out_valid_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[NStage-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      value_o         <= fmt_q ? {16'd0, f32_to_f16(f32_q)} : f32_q;
      element_index_o <= meta_q[NStage-1].idx;
      last_in_run_o   <= meta_q[NStage-1].lrun;
      last_in_block_o <= meta_q[NStage-1].lblk;
    end
  end

endmodule

### hw/rtl/q5k_superblock_dequantizer.sv
// Top level of the Q5_K super-block dequantizer: joins the sequencer
// q5k_ctrl and the datapath q5k_dp. Uses q5k_pkg.
//
//  channel  direction  handshake                 payload
//  in       request    in_valid_i / in_ready_o   data_word_i
//  out      result     out_valid_o / out_ready_i value_o, element_index_o,
//                                                last_in_run_o, last_in_block_o
//  cfg      write      cfg_we_i                  cfg_wdata_i
//
// A word that only fills storage leaves the sequencer idle. The fourth word of
// each nibble chunk starts a run of 64 results, issued one per cycle while the
// output is not stalled, into the element pipeline; the next word is taken
// once that pipeline has drained. A stalled output freezes the whole pipeline.
// Reset clears the word position, the sequencer and output_format; no
// clearing pass is run.
module q5k_superblock_dequantizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] data_word_i,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] value_o,
  output logic [7:0]  element_index_o,
  output logic        last_in_run_o,
  output logic        last_in_block_o
);
  import q5k_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  q5k_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  q5k_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .data_word_i     (data_word_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .value_o         (value_o),
    .element_index_o (element_index_o),
    .last_in_run_o   (last_in_run_o),
    .last_in_block_o (last_in_block_o)
  );

endmodule

### hw/rtl/q5k_checker.sv
// Port-level checks for q5k_superblock_dequantizer, attached by bind.
// No package dependencies.
module q5k_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] value_o,
  input logic [7:0]  element_index_o,
  input logic        last_in_run_o,
  input logic        last_in_block_o
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o))
    else $error("stalled result changed");

  // take no request while a run is still in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> !out_valid_o)
    else $error("request taken during a run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_in_block_o |-> last_in_run_o && element_index_o == 8'd255)
    else $error("block end flag misplaced");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> last_in_run_o == (element_index_o[5:0] == 6'd63))
    else $error("run end flag misplaced");

endmodule

bind q5k_superblock_dequantizer q5k_checker u_q5k_checker (.*);

### tb/tb_q5k_superblock_dequantizer.sv
// Testbench for the Q5_K super-block dequantizer: streams super-blocks as
// 64-bit words, predicts every weight in-bench and checks it. Uses q5k_pkg.
`timescale 1ns / 100ps
module tb_q5k_superblock_dequantizer;
  import q5k_pkg::*;

  localparam logic FMT_F32 = 1'b0;
  localparam logic FMT_F16 = 1'b1;
  localparam int   IDLE_LIMIT = 4000;

  typedef struct {
    logic [31:0] value;
    logic [7:0]  index;
    logic        run_end;
    logic        block_end;
  } weight_t;

  typedef struct {
    logic [63:0] word;
    logic        chk;
    logic [31:0] first_value;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] data_word_i = '0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] value_o;
  logic [7:0]  element_index_o;
  logic        last_in_run_o;
  logic        last_in_block_o;

  weight_t     weights_due[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;

  // predictor state
  logic        fmt_q;
  logic [4:0]  pos_q;
  logic [15:0] d_half, dmin_half;
  logic [7:0]  sbytes [12];
  logic [7:0]  hbytes [32];
  logic [7:0]  nbytes [32];

  always #6 clk_i = ~clk_i;

  q5k_superblock_dequantizer u_top (.*);

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [31:0] s;
    logic [4:0]  e;
    logic [10:0] m;
    int          n;
    s = {h[15], 31'd0};
    e = h[14:10];
    m = {1'b0, h[9:0]};
    n = 1;
    if (e == 5'd0) begin
      if (m == '0) return s;
      while (!m[10]) begin
        m = m << 1;
        n++;
      end
      return s | (32'(114 - n) << 23) | (32'(m[9:0]) << 13);
    end
    if (e == 5'd31) return s | 32'h7F80_0000 | (32'(m[9:0]) << 13);
    return s | (32'(e + 112) << 23) | (32'(m[9:0]) << 13);
  endfunction

  function automatic real single_to_real(input logic [31:0] u);
    logic [63:0] b;
    b = {u[31], 63'd0};
    if (u[30:23] == 8'hFF) b[62:0] = {11'h7FF, u[22:0], 29'd0};
    else if (u[30:0] != '0) b[62:0] = {11'(u[30:23] + 896), u[22:0], 29'd0};
    return $bitstoreal(b);
  endfunction

  // round a double to fp32, nearest even; fp32 subnormals cannot arise here
  function automatic logic [31:0] real_to_single(input real v);
    logic [63:0] b;
    logic [10:0] e;
    logic [28:0] rem;
    logic [24:0] m;
    logic [8:0]  ex;
    b = $realtobits(v);
    e = b[62:52];
    if (e == 11'h7FF) return (b[51:0] != '0) ? QNan32 : {b[63], 31'h7F80_0000};
    if (e == 11'd0) return {b[63], 31'd0};
    m   = {2'b01, b[51:29]};
    rem = b[28:0];
    ex  = 9'(e - 896);
    if (rem > 29'h1000_0000 || (rem == 29'h1000_0000 && m[0])) m = m + 25'd1;
    if (m[24]) begin
      m  = m >> 1;
      ex = ex + 9'd1;
    end
    return {b[63], ex[7:0], m[22:0]};
  endfunction

  function automatic logic [15:0] narrow_to_half(input logic [31:0] u);
    logic        s;
    int          e, sh;
    logic [31:0] m, r, hlf;
    s = u[31];
    m = {9'd0, u[22:0]};
    if (u[30:23] == 8'hFF) return (m != '0) ? QNan16 : {s, 15'h7C00};
    e = int'(u[30:23]) - 112;
    if (e <= 0) begin
      if (e < -10) return {s, 15'd0};
      m   = m | 32'h80_0000;
      sh  = 14 - e;
      hlf = 32'd1 << (sh - 1);
      r   = m & ((32'd1 << sh) - 1);
      m   = m >> sh;
      if (r > hlf || (r == hlf && m[0])) m++;
      return {s, m[14:0]};
    end
    if (e >= 31) return {s, 15'h7C00};
    r = m & 32'h1FFF;
    m = m >> 13;
    if (r > 32'h1000 || (r == 32'h1000 && m[0])) begin
      m++;
      if (m == 32'h400) begin
        m = 0;
        e++;
      end
      if (e >= 31) return {s, 15'h7C00};
    end
    return {s, 5'(e), m[9:0]};
  endfunction

  // take one word into the predictor state; queue 64 weights on a chunk end
  task automatic absorb_word(input logic [63:0] w);
    logic [4:0]  p;
    int          sb, sc, mn, q, k;
    real         d, dmin, dsc, mmn;
    logic [31:0] bits;
    weight_t     wt;
    p = pos_q;
    pos_q = (p == PosLast) ? PosHdr0 : p + 5'd1;
    if (p == PosHdr0) begin
      d_half    = w[15:0];
      dmin_half = w[31:16];
      for (int i = 0; i < 4; i++) sbytes[i] = w[32+8*i +: 8];
      return;
    end
    if (p == PosHdr1) begin
      for (int i = 0; i < 8; i++) sbytes[4+i] = w[8*i +: 8];
      return;
    end
    if (p < NibbleBase) begin
      for (int i = 0; i < 8; i++) hbytes[(p-2)*8+i] = w[8*i +: 8];
      return;
    end
    for (int i = 0; i < 8; i++) nbytes[((p-NibbleBase)%4)*8+i] = w[8*i +: 8];
    if ((p - NibbleBase) % 4 != 3) return;
    d    = single_to_real(half_to_single(d_half));
    dmin = single_to_real(half_to_single(dmin_half));
    for (int hf = 0; hf < 2; hf++) begin
      sb = 2 * ((p - NibbleBase) / 4) + hf;
      if (sb < 4) begin
        sc = sbytes[sb] & 8'h3F;
        mn = sbytes[sb+4] & 8'h3F;
      end else begin
        sc = (sbytes[sb+4] & 8'h0F) | ((sbytes[sb-4] >> 6) << 4);
        mn = (sbytes[sb+4] >> 4) | ((sbytes[sb] >> 6) << 4);
      end
      dsc = d * sc;
      mmn = dmin * mn;
      for (int l = 0; l < 32; l++) begin
        k = hf * 32 + l;
        q = (hf ? nbytes[l][7:4] : nbytes[l][3:0]) + (hbytes[l][sb] ? 16 : 0);
        // both products and the difference are exact in double precision
        bits = real_to_single(dsc * q - mmn);
        if (bits[30:0] > 31'h7F80_0000) bits = QNan32;
        if (fmt_q == FMT_F16) bits = {16'd0, narrow_to_half(bits)};
        wt.value     = bits;
        wt.index     = 8'(((p - NibbleBase) / 4) * 64 + k);
        wt.run_end   = (k == 63);
        wt.block_end = (wt.index == 8'd255);
        weights_due.push_back(wt);
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_word(input logic [63:0] w, input bit gaps);
    int gap;
    gap = gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_word(w);
  endtask

  // hold the input idle until every weight is out, then let the pipe settle
  task automatic drain_and_set(input logic fmt);
    in_valid_i <= 1'b0;
    while (weights_due.size() != 0) @(posedge clk_i);
    repeat (90) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= fmt;
    @(posedge clk_i);
    fmt_q = fmt;
    cfg_we_i <= 1'b0;
  endtask

  // result side: check, then choose the next ready level
  always @(posedge clk_i) begin
    weight_t wt;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (weights_due.size() == 0) begin
        $display("%0t: unexpected result index %0d value %h", $time, element_index_o,
                 value_o);
        errors++;
      end else begin
        wt = weights_due.pop_front();
        if (value_o !== wt.value) begin
          $display("%0t: value idx %0d expected %h actual %h", $time, wt.index, wt.value,
                   value_o);
          errors++;
        end
        if (element_index_o !== wt.index) begin
          $display("%0t: element_index expected %0d actual %0d", $time, wt.index,
                   element_index_o);
          errors++;
        end
        if (last_in_run_o !== wt.run_end) begin
          $display("%0t: last_in_run idx %0d expected %b actual %b", $time, wt.index,
                   wt.run_end, last_in_run_o);
          errors++;
        end
        if (last_in_block_o !== wt.block_end) begin
          $display("%0t: last_in_block idx %0d expected %b actual %b", $time, wt.index,
                   wt.block_end, last_in_block_o);
          errors++;
        end
      end
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 9) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    stim_row_t   rows [22];
    logic [63:0] w;
    logic [31:0] r;
    // infinite d with a zero weight gives NaN; mixed scale and high-bit patterns
    rows[0]  = '{64'hC03F_00FF_3C00_7C00, 1'b0, '0};
    rows[1]  = '{64'hFF00_F00F_3FC0_0001, 1'b0, '0};
    rows[2]  = '{64'hFFFF_FFFF_FFFF_FF00, 1'b0, '0};
    rows[3]  = '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0};
    rows[4]  = '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0};
    rows[5]  = '{64'h5555_5555_5555_5555, 1'b0, '0};
    rows[6]  = '{64'hFFFF_FFFF_F00F_0F00, 1'b0, '0};
    rows[7]  = '{64'h0000_0000_0000_0000, 1'b0, '0};
    rows[8]  = '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0};
    rows[9]  = '{64'h1234_5678_9ABC_DEF0, 1'b1, QNan32};
    for (int i = 10; i < 22; i++) rows[i] = '{{$urandom, $urandom}, 1'b0, '0};
    rows[10].word = '0;
    rows[21].word = '1;

    fmt_q = FMT_F32;
    pos_q = PosHdr0;
    d_half = '0;
    dmin_half = '0;
    foreach (sbytes[i]) sbytes[i] = '0;
    foreach (hbytes[i]) hbytes[i] = '0;
    foreach (nbytes[i]) nbytes[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drain_and_set(FMT_F32);
    foreach (rows[i]) begin
      send_word(rows[i].word, 1'b1);
      if (rows[i].chk) begin
        r = weights_due[weights_due.size() - 64].value;
        if (r !== rows[i].first_value) begin
          $display("%0t: row %0d expected %h predicted %h", $time, i, rows[i].first_value, r);
          errors++;
        end
      end
    end

    // random blocks, alternating formats with a few random picks
    for (int blk = 0; blk < 9; blk++) begin
      drain_and_set(blk < 2 ? FMT_F16 - blk[0] : logic'($urandom_range(0, 1)));
      for (int i = 0; i < 22; i++) begin
        w = {$urandom, $urandom};
        if (i == 0 && $urandom_range(0, 2) == 0) begin
          // pull d into ranges that overflow or underflow fp16
          w[14:10] = $urandom_range(0, 1) ? 5'($urandom_range(12, 30))
                                          : 5'($urandom_range(0, 3));
        end
        send_word(w, blk != 4);
      end
    end
    in_valid_i <= 1'b0;
    while (weights_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/q5k_pkg.sv
hw/rtl/q5k_ctrl.sv
hw/rtl/q5k_dp.sv
hw/rtl/q5k_superblock_dequantizer.sv
hw/rtl/q5k_checker.sv
tb/tb_q5k_superblock_dequantizer.sv
